>>> hdl/sef_pkg.sv
// ----------------------------------------------------------------------------
// sef_pkg
// shared types, codes and constants of the rgb sobel edge filter
// ----------------------------------------------------------------------------
package sef_pkg;

    localparam int CFG_W   = 11;
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int GRAD_W  = 11;
    localparam int SQ_W    = 21;
    localparam int AREA_W  = 2 * CFG_W;
    localparam int CFG_RST = 1024;
    localparam int SAT_SUM = 65280;
    localparam int CH_MAX  = 255;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam int KERN_X [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
    localparam int KERN_Y [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

    typedef struct packed {
        logic       op;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] edge_red;
        logic [7:0] edge_green;
        logic [7:0] edge_blue;
        logic       frame_end;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_GRAD,
        ST_SQR,
        ST_ROOT,
        ST_ROUND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic shift;
        logic grad;
        logic sqr;
        logic step;
        logic round;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic drop;
        logic emit;
        logic root_done;
        logic out_free;
    } t_status;

endpackage

>>> hdl/sef_ram.sv
// ----------------------------------------------------------------------------
// sef_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sef_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sef_ctrl.sv
// ----------------------------------------------------------------------------
// sef_ctrl
// sequencer of one request: window shift, gradients, squares, root, output
// ----------------------------------------------------------------------------
module sef_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  sef_pkg::t_status i_status,
    output sef_pkg::t_cmd    o_cmd,
    output logic             o_in_stall
);

    sef_pkg::t_state r_state;
    sef_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sef_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            sef_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && !i_status.drop) begin
                    o_cmd.accept = 1'b1;
                    n_state      = sef_pkg::ST_SHIFT;
                end
            end
            sef_pkg::ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = i_status.emit ? sef_pkg::ST_GRAD : sef_pkg::ST_IDLE;
            end
            sef_pkg::ST_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state    = sef_pkg::ST_SQR;
            end
            sef_pkg::ST_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = sef_pkg::ST_ROOT;
            end
            sef_pkg::ST_ROOT: begin
                if (i_status.root_done) begin
                    n_state = sef_pkg::ST_ROUND;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            sef_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = sef_pkg::ST_OUT;
            end
            sef_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sef_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sef_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/sef_datapath.sv
// ----------------------------------------------------------------------------
// sef_datapath
// line buffers, 3x3 window, sobel gradients, serial square root, output reg
// ----------------------------------------------------------------------------
module sef_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sef_pkg::t_cmd              i_cmd,
    output sef_pkg::t_status           o_status,
    input  sef_pkg::t_in_item          i_in,
    output logic                       o_out_valid,
    output sef_pkg::t_out_item         o_out,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [sef_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT + 5);
    localparam int MW  = (RW > CW) ? ((RW > sef_pkg::CFG_W) ? RW : sef_pkg::CFG_W)
                                   : ((CW > sef_pkg::CFG_W) ? CW : sef_pkg::CFG_W);
    localparam int PW  = MW + 2;
    localparam int CFW = sef_pkg::CFG_W;
    localparam int PXW = sef_pkg::PIX_W;
    localparam int GW  = sef_pkg::GRAD_W;
    localparam int SW  = sef_pkg::SQ_W;
    localparam int AW  = sef_pkg::AREA_W;
    localparam int ROW_SAT = MAX_HEIGHT + 4;

    logic [CFW-1:0] r_cfg_w, r_cfg_h;
    logic [CFW-1:0] eff_w, eff_h;

    logic [CW-1:0]  r_in_col;
    logic [RW-1:0]  r_in_row;
    logic [AW-1:0]  r_out_index;
    logic [PXW-1:0] r_v;
    logic [PXW-1:0] r_win [3][3];
    logic [PXW-1:0] r_g   [3][3];
    logic signed [PW-1:0] r_cr, r_cc;
    logic signed [GW-1:0] r_gx [3];
    logic signed [GW-1:0] r_gy [3];
    logic signed [GW-1:0] gx [3];
    logic signed [GW-1:0] gy [3];
    logic [SW-1:0]  r_s [3];
    logic [7:0]     r_n [3];
    logic [7:0]     r_b;
    logic [7:0]     r_e [3];
    logic [7:0]     e_val [3];
    logic           r_fe;
    logic [AW-1:0]  r_area;
    logic           r_out_valid;
    sef_pkg::t_out_item r_out;

    logic [PXW-1:0] rd_up, rd_mid;
    logic           emit;
    logic [CW:0]    col_inc;

    // effective sizes
    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = CFW'(1);
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = CFW'(MAX_WIDTH);
        end else begin
            eff_w = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            eff_h = CFW'(1);
        end else if (int'(r_cfg_h) > MAX_HEIGHT) begin
            eff_h = CFW'(MAX_HEIGHT);
        end else begin
            eff_h = r_cfg_h;
        end
    end

    sef_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_in_col),
        .i_wdata (rd_mid),
        .i_raddr (r_in_col),
        .o_rdata (rd_up)
    );

    sef_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_in_col),
        .i_wdata (r_v),
        .i_raddr (r_in_col),
        .o_rdata (rd_mid)
    );

    assign emit    = (int'(r_in_row) >= 2) || ((r_in_row == RW'(1)) && (r_in_col != '0));
    assign col_inc = {1'b0, r_in_col} + (CW+1)'(1);

    // masked sobel sums
    always_comb begin
        int ax, ay, pr, pc, p;
        for (int ch = 0; ch < 3; ch++) begin
            ax = 0;
            ay = 0;
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    pr = int'(r_cr) + j - 1;
                    pc = int'(r_cc) + k - 1;
                    p  = int'(r_g[j][k][8*ch +: 8]);
                    if (pr < 0 || pr >= int'(eff_h) || pc < 0 || pc >= int'(eff_w)) begin
                        p = 0;
                    end
                    ax = ax + sef_pkg::KERN_X[j][k] * p;
                    ay = ay + sef_pkg::KERN_Y[j][k] * p;
                end
            end
            gx[ch] = GW'(ax);
            gy[ch] = GW'(ay);
        end
    end

    // rounding and clamp
    always_comb begin
        logic [15:0] nsq;
        logic [SW-1:0] rem;
        logic [8:0] nr;
        for (int ch = 0; ch < 3; ch++) begin
            nsq = 16'(r_n[ch]) * 16'(r_n[ch]);
            rem = r_s[ch] - SW'(nsq);
            nr  = (rem > SW'(r_n[ch])) ? (9'(r_n[ch]) + 9'd1) : 9'(r_n[ch]);
            if (int'(r_s[ch]) > sef_pkg::SAT_SUM || int'(nr) > sef_pkg::CH_MAX) begin
                e_val[ch] = 8'(sef_pkg::CH_MAX);
            end else begin
                e_val[ch] = nr[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [7:0]  t;
        logic [15:0] tsq;
        if (!i_rst_n) begin
            r_cfg_w     <= CFW'(sef_pkg::CFG_RST);
            r_cfg_h     <= CFW'(sef_pkg::CFG_RST);
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_index <= '0;
            r_b         <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[j][k] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sef_pkg::CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_data;
                    sef_pkg::CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_v <= i_in.op ? '0 : {i_in.blue_in, i_in.green_in, i_in.red_in};
            end
            if (i_cmd.shift) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[j][0] <= r_win[j][1];
                    r_win[j][1] <= r_win[j][2];
                end
                r_win[0][2] <= rd_up;
                r_win[1][2] <= rd_mid;
                r_win[2][2] <= r_v;
                if (r_in_col == '0) begin
                    for (int j = 0; j < 3; j++) begin
                        r_g[j][0] <= r_win[j][1];
                        r_g[j][1] <= r_win[j][2];
                        r_g[j][2] <= '0;
                    end
                    r_cr <= $signed(PW'(r_in_row)) - PW'(2);
                    r_cc <= $signed(PW'(eff_w)) - PW'(1);
                end else begin
                    for (int j = 0; j < 3; j++) begin
                        r_g[j][0] <= r_win[j][1];
                        r_g[j][1] <= r_win[j][2];
                    end
                    r_g[0][2] <= rd_up;
                    r_g[1][2] <= rd_mid;
                    r_g[2][2] <= r_v;
                    r_cr <= $signed(PW'(r_in_row)) - PW'(1);
                    r_cc <= $signed(PW'(r_in_col)) - PW'(1);
                end
                if (int'(col_inc) >= int'(eff_w)) begin
                    r_in_col <= '0;
                    if (int'(r_in_row) < ROW_SAT) begin
                        r_in_row <= r_in_row + RW'(1);
                    end
                end else begin
                    r_in_col <= col_inc[CW-1:0];
                end
            end
            if (i_cmd.grad) begin
                for (int ch = 0; ch < 3; ch++) begin
                    r_gx[ch] <= gx[ch];
                    r_gy[ch] <= gy[ch];
                end
                r_area <= AW'(eff_w) * AW'(eff_h);
            end
            if (i_cmd.sqr) begin
                for (int ch = 0; ch < 3; ch++) begin
                    r_s[ch] <= SW'(r_gx[ch]) * SW'(r_gx[ch]) + SW'(r_gy[ch]) * SW'(r_gy[ch]);
                    r_n[ch] <= '0;
                end
                r_b <= 8'h80;
            end
            if (i_cmd.step) begin
                for (int ch = 0; ch < 3; ch++) begin
                    t   = r_n[ch] | r_b;
                    tsq = 16'(t) * 16'(t);
                    if (SW'(tsq) <= r_s[ch]) begin
                        r_n[ch] <= t;
                    end
                end
                r_b <= r_b >> 1;
            end
            if (i_cmd.round) begin
                for (int ch = 0; ch < 3; ch++) begin
                    r_e[ch] <= e_val[ch];
                end
                r_fe <= (r_out_index + AW'(1)) >= r_area;
            end
            if (i_cmd.out_load) begin
                r_out_valid      <= 1'b1;
                r_out.edge_red   <= r_e[0];
                r_out.edge_green <= r_e[1];
                r_out.edge_blue  <= r_e[2];
                r_out.frame_end  <= r_fe;
                if (r_fe) begin
                    r_in_row    <= '0;
                    r_in_col    <= '0;
                    r_out_index <= '0;
                end else begin
                    r_out_index <= r_out_index + AW'(1);
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.drop      = i_in.op ? (int'(r_in_row) < int'(eff_h))
                                        : (int'(r_in_row) >= int'(eff_h));
    assign o_status.emit      = emit;
    assign o_status.root_done = (r_b == '0);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;

`ifndef SYNTHESIS
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_fe) |=> (r_out_index == '0 && r_in_row == '0 && r_in_col == '0))
        else $error("counters not cleared at frame end");
    a_root_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_b))
        else $error("root bit not one-hot");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_in_col) < MAX_WIDTH)
        else $error("column beyond line buffer");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output overwritten");
`endif

endmodule

>>> hdl/sobel_rgb_edge_filter_unit.sv
// a pixel that causes no result only shifts the window, a dropped request is discarded in idle
// a request that yields a result runs the full sequence and waits out any output stall
// the 8-step serial square root sets the result path; one request at a time
// results appear one row plus one pixel of requests after their pixel
// synchronous active-low reset clears counters, window and sizes (1024 x 1024)
// ----------------------------------------------------------------------------
// sobel_rgb_edge_filter_unit
// streaming 3x3 sobel edge magnitude on rgb pixels with two line buffers
// ----------------------------------------------------------------------------
module sobel_rgb_edge_filter_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  sef_pkg::t_in_item          i_in,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output sef_pkg::t_out_item         o_out,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [sef_pkg::CFG_W-1:0]  i_cfg_data
);

    sef_pkg::t_cmd    cmd;
    sef_pkg::t_status status;

    sef_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    sef_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
